>>> sv/universal_machine_execute_unit_macros.svh
// Assertion macros shared by the execute unit files
`ifndef UNIVERSAL_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define UNIVERSAL_MACHINE_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define UMX_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UMX_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UMX_ASSERT(label, clk, rst_n, prop, msg)
`define UMX_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> sv/umx_pkg.sv
package umx_pkg;
	typedef enum logic [3:0] {
		ACT_NONE = 4'd0, ACT_LOAD = 4'd1, ACT_STORE = 4'd2, ACT_MAP = 4'd3,
		ACT_UNMAP = 4'd4, ACT_OUTPUT = 4'd5, ACT_INPUT = 4'd6, ACT_LOADPROG = 4'd7,
		ACT_HALT = 4'd8
	} action_t;

	typedef enum logic [1:0] {
		FLT_NONE = 2'd0, FLT_OPCODE = 2'd1, FLT_DIVZERO = 2'd2, FLT_OUTRANGE = 2'd3
	} fault_t;

	typedef enum logic [3:0] {
		OPC_CMOV = 4'd0, OPC_LOAD = 4'd1, OPC_STORE = 4'd2, OPC_ADD = 4'd3,
		OPC_MUL = 4'd4, OPC_DIV = 4'd5, OPC_NAND = 4'd6, OPC_HALT = 4'd7,
		OPC_MAP = 4'd8, OPC_UNMAP = 4'd9, OPC_OUT = 4'd10, OPC_IN = 4'd11,
		OPC_LOADPROG = 4'd12, OPC_LDIMM = 4'd13, OPC_BAD0 = 4'd14, OPC_BAD1 = 4'd15
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_DONE
	} state_t;

	localparam int unsigned DIV_STEPS = 32;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch input transfer
		logic execute;   // decode, write back, form result
		logic div_start; // begin iterative divide
		logic div_finish;// write quotient and form result
	} umx_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_div;    // captured item is a real divide
		logic div_done;
	} umx_status_t;
endpackage

>>> sv/umx_divider.sv
module umx_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import umx_pkg::*;

	logic [31:0] rem_q, quo_q, dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[31]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = !busy_q && !start;
	assign quotient = quo_q;
endmodule

>>> sv/umx_datapath.sv
module umx_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  umx_pkg::umx_cmd_t    cmd,
	output umx_pkg::umx_status_t status,
	input  logic                 op,
	input  logic [31:0]          instruction,
	input  logic [31:0]          reply_value,
	output logic [3:0]           action,
	output logic [1:0]           fault,
	output logic [31:0]          segment_id,
	output logic [31:0]          segment_offset,
	output logic [31:0]          store_data,
	output logic [7:0]           out_char,
	output logic [31:0]          next_pc
);
	import umx_pkg::*;

	logic [31:0] regs_q [8];
	logic [31:0] pc_q;
	logic        pend_q;
	logic [2:0]  preg_q;

	logic        op_q;
	logic [31:0] word_q, reply_q;
	logic [31:0] va_q, vb_q, vc_q;

	logic [3:0]  act_q;
	logic [1:0]  flt_q;
	logic [31:0] seg_q, off_q, sd_q;
	logic [7:0]  ch_q;

	opcode_t     opc;
	logic [2:0]  ra, rb, rc;
	logic [31:0] vb_rd, vc_rd, va_rd;
	logic        div_done;
	logic [31:0] quotient;
	logic [31:0] mul_res;

	assign opc = opcode_t'(word_q[31:28]);
	assign ra  = word_q[8:6];
	assign rb  = word_q[5:3];
	assign rc  = word_q[2:0];
	assign mul_res = vb_q * vc_q;

	// operand read from the incoming instruction word, captured with it
	assign va_rd = regs_q[instruction[8:6]];
	assign vb_rd = regs_q[instruction[5:3]];
	assign vc_rd = regs_q[instruction[2:0]];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			word_q  <= instruction;
			reply_q <= reply_value;
			va_q    <= va_rd;
			vb_q    <= vb_rd;
			vc_q    <= vc_rd;
		end
	end

	umx_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (vb_q),
		.divisor  (vc_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign status.is_div   = !op_q && !pend_q && (opc == OPC_DIV) && (vc_q != '0);
	assign status.div_done = div_done;

	// architectural state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) regs_q[i] <= '0;
			pc_q   <= '0;
			pend_q <= 1'b0;
			preg_q <= '0;
			act_q  <= ACT_NONE;
			flt_q  <= FLT_NONE;
			seg_q  <= '0;
			off_q  <= '0;
			sd_q   <= '0;
			ch_q   <= '0;
		end else if (cmd.div_finish) begin
			regs_q[ra] <= quotient;
			pc_q  <= pc_q + 32'd1;
			act_q <= ACT_NONE;
			flt_q <= FLT_NONE;
			seg_q <= '0;
			off_q <= '0;
			sd_q  <= '0;
			ch_q  <= '0;
		end else if (cmd.execute) begin
			act_q <= ACT_NONE;
			flt_q <= FLT_NONE;
			seg_q <= '0;
			off_q <= '0;
			sd_q  <= '0;
			ch_q  <= '0;
			if (op_q) begin
				if (pend_q) begin
					regs_q[preg_q] <= reply_q;
					pend_q <= 1'b0;
				end
			end else if (!pend_q) begin
				unique case (opc)
					OPC_CMOV: begin
						if (vc_q != '0) regs_q[ra] <= vb_q;
						pc_q <= pc_q + 32'd1;
					end
					OPC_LOAD: begin
						pend_q <= 1'b1; preg_q <= ra;
						pc_q <= pc_q + 32'd1;
						act_q <= ACT_LOAD; seg_q <= vb_q; off_q <= vc_q;
					end
					OPC_STORE: begin
						pc_q <= pc_q + 32'd1;
						act_q <= ACT_STORE; seg_q <= va_q; off_q <= vb_q; sd_q <= vc_q;
					end
					OPC_ADD: begin
						regs_q[ra] <= vb_q + vc_q;
						pc_q <= pc_q + 32'd1;
					end
					OPC_MUL: begin
						regs_q[ra] <= mul_res;
						pc_q <= pc_q + 32'd1;
					end
					OPC_DIV: flt_q <= FLT_DIVZERO; // nonzero divisor goes to divider
					OPC_NAND: begin
						regs_q[ra] <= ~(vb_q & vc_q);
						pc_q <= pc_q + 32'd1;
					end
					OPC_HALT: act_q <= ACT_HALT;
					OPC_MAP: begin
						pend_q <= 1'b1; preg_q <= rb;
						pc_q <= pc_q + 32'd1;
						act_q <= ACT_MAP; off_q <= vc_q;
					end
					OPC_UNMAP: begin
						pc_q <= pc_q + 32'd1;
						act_q <= ACT_UNMAP; seg_q <= vc_q;
					end
					OPC_OUT: begin
						if (vc_q > 32'd255) flt_q <= FLT_OUTRANGE;
						else begin
							pc_q <= pc_q + 32'd1;
							act_q <= ACT_OUTPUT; ch_q <= vc_q[7:0];
						end
					end
					OPC_IN: begin
						pend_q <= 1'b1; preg_q <= rc;
						pc_q <= pc_q + 32'd1;
						act_q <= ACT_INPUT;
					end
					OPC_LOADPROG: begin
						pc_q <= vc_q;
						act_q <= ACT_LOADPROG; seg_q <= vb_q;
					end
					OPC_LDIMM: begin
						regs_q[word_q[27:25]] <= {7'd0, word_q[24:0]};
						pc_q <= pc_q + 32'd1;
					end
					default: flt_q <= FLT_OPCODE;
				endcase
			end
		end
	end

	assign action         = act_q;
	assign fault          = flt_q;
	assign segment_id     = seg_q;
	assign segment_offset = off_q;
	assign store_data     = sd_q;
	assign out_char       = ch_q;
	assign next_pc        = pc_q;

`include "universal_machine_execute_unit_macros.svh"
	// a request that waits for a reply marks it pending
	`UMX_ASSERT(a_pend_set, clk, arst_n, (cmd.execute && !op_q && !pend_q && (opc == OPC_LOAD || opc == OPC_MAP || opc == OPC_IN)) |=> pend_q, "request did not set pending")
	// faults never come with an action
	`UMX_ASSERT(a_fault_noact, clk, arst_n, (flt_q != FLT_NONE) |-> (act_q == ACT_NONE), "fault with action")
	// pc holds on a bad opcode (OPC_BAD0)
	`UMX_ASSERT(a_fault_pc, clk, arst_n, (cmd.execute && !op_q && !pend_q && opc == OPC_BAD0) |=> $stable(pc_q), "pc moved on bad opcode")
endmodule

>>> sv/umx_control.sv
module umx_control (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output umx_pkg::umx_cmd_t    cmd,
	input  umx_pkg::umx_status_t status
);
	import umx_pkg::*;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EXEC;
			ST_EXEC: state_d = status.is_div ? ST_DIV : ST_DONE;
			ST_DIV:  if (status.div_done) state_d = ST_DONE;
			ST_DONE: if (out_ready) state_d = in_valid ? ST_EXEC : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.execute   = !status.is_div;
				cmd.div_start = status.is_div;
			end
			ST_DIV: cmd.div_finish = status.div_done;
			ST_DONE: begin
				out_valid   = 1'b1;
				in_ready    = out_ready;
				cmd.capture = out_ready && in_valid;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

`include "universal_machine_execute_unit_macros.svh"
	`UMX_ASSERT(a_no_both, clk, arst_n, !(cmd.execute && cmd.div_start), "execute and divide together")
	`UMX_ASSERT(a_div_path, clk, arst_n, cmd.div_start |=> (state_q == ST_DIV), "divide not entered")
	`UMX_ASSERT(a_finish_done, clk, arst_n, cmd.div_finish |=> (state_q == ST_DONE), "divide finish lost")
endmodule

>>> sv/universal_machine_execute_unit.sv
// Channel | Handshake         | Payload
// in      | in_valid/in_ready | op, instruction, reply_value
// out     | out_valid/out_ready | action, fault, segment_id, segment_offset,
//         |                   | store_data, out_char, next_pc
// An item goes through operand capture, then execute and write back.
// A divide with nonzero divisor also goes through the bit-serial divider.
// The result register holds until taken; the next item is captured in the same cycle.
// Reset clears registers, pc, pending flag and result.
module universal_machine_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [31:0] instruction,
	input  logic [31:0] reply_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  action,
	output logic [1:0]  fault,
	output logic [31:0] segment_id,
	output logic [31:0] segment_offset,
	output logic [31:0] store_data,
	output logic [7:0]  out_char,
	output logic [31:0] next_pc
);
	import umx_pkg::*;

	umx_cmd_t    cmd;
	umx_status_t status;

	umx_control u_ctl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.cmd, .status
	);

	umx_datapath u_dp (
		.clk, .arst_n, .cmd, .status, .op, .instruction, .reply_value,
		.action, .fault, .segment_id, .segment_offset, .store_data,
		.out_char, .next_pc
	);
endmodule
